// ----- hw/rtl/dtat_pkg.sv -----
`timescale 1ns / 1ps

package dtat_pkg;

  localparam int unsigned ID_W       = 32;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TLIMIT_W   = 5;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_TIME   = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_BYPASS = 2'd0,
    VERDICT_KNOWN  = 2'd1,
    VERDICT_ADDED  = 2'd2,
    VERDICT_FULL   = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [ID_W-1:0]    target_id;
    logic [LEVEL_W-1:0] requester_level;
    logic [TIME_W-1:0]  now_seconds;
  } req_t;

  typedef struct packed {
    logic               allowed;
    logic [1:0]         verdict;
    logic [COUNT_W-1:0] entries_in_use;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   key;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

// ----- hw/rtl/dtat_store.sv -----
`timescale 1ns / 1ps

module dtat_store #(
  parameter int unsigned Entries = 16,
  parameter int unsigned IdxW    = 4
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [IdxW-1:0]   rd_addr_i,
  output dtat_pkg::entry_t  rd_data_o,
  input  logic              wr_en_i,
  input  logic [IdxW-1:0]   wr_addr_i,
  input  dtat_pkg::entry_t  wr_data_i
);
  import dtat_pkg::*;

  entry_t mem_q [Entries];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- hw/rtl/distinct_target_admission_table.sv -----
`timescale 1ns / 1ps

// Admission table for up to TABLE_ENTRIES distinct target ids. One request is
// handled at a time. The input stalls from the cycle after a request is
// accepted until its response is loaded into the output register, and it is
// ready again as soon as that response is loaded. A bypassed request goes from
// the check straight to its response. A request that is looked up makes one
// pass over the table, entry by entry behind a registered read. A known
// target ends the pass at its entry, and an added or refused one goes on to a
// decide step after the pass. When the table is at its limit, a second pass
// ages out old entries first. A stalled response holds the block until it is
// taken. Both passes read the entry memory one entry a cycle and share one
// 32-bit subtractor that does both the id compare and the age check.
// The table is empty after reset and needs no clearing pass.

module distinct_target_admission_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dtat_pkg::req_t                      req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dtat_pkg::rsp_t                      rsp_o,
  input  logic                                cfg_we_i,
  input  logic [dtat_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dtat_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import dtat_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > TLIMIT_W) ? CNT_W : TLIMIT_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_MATCH  = 3'd2;
  localparam logic [2:0] ST_DECAY  = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // Configuration registers.
  logic [TLIMIT_W-1:0] tlimit_q;
  logic [LEVEL_W-1:0]  bypass_q;
  logic [TIME_W-1:0]   decay_q;

  logic [2:0]           state_q, state_d;
  req_t                 req_q;
  logic [IDX_W:0]       addr_q, addr_d;
  logic                 pipe_vld_q, pipe_vld_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]     free_q, free_d;
  logic                 free_hit_q, free_hit_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  verdict_e             verdict_q, verdict_d;
  logic                 out_vld_q, out_vld_d;
  rsp_t                 rsp_q, rsp_d;

  logic             rd_en;
  entry_t           rd_data;
  logic             wr_en;
  entry_t           wr_data;
  logic [TIME_W-1:0] op_a, op_b, diff;
  logic             key_hit, aged, cur_valid, last_entry, full;
  logic [CMP_W-1:0] cnt_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlimit_q <= '0;
      bypass_q <= '1;
      decay_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_LIMIT: tlimit_q <= cfg_data_i[TLIMIT_W-1:0];
        CFG_BYPASS_LEVEL: bypass_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_DECAY_TIME:   decay_q  <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  dtat_store #(
    .Entries (TABLE_ENTRIES),
    .IdxW    (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q[IDX_W-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (free_q),
    .wr_data_i (wr_data)
  );

  assign wr_data.key   = req_q.target_id;
  assign wr_data.stamp = req_q.now_seconds;

  // Shared subtractor: in a match a zero difference is an id match; in decay it is the age.
  assign op_a    = (state_q == ST_DECAY) ? req_q.now_seconds : req_q.target_id;
  assign op_b    = (state_q == ST_DECAY) ? rd_data.stamp : rd_data.key;
  assign diff    = op_a - op_b;
  assign key_hit = (diff == '0);
  assign aged    = (diff >= decay_q);

  assign cur_valid  = valid_q[cmp_idx_q];
  assign last_entry = (cmp_idx_q == IDX_W'(TABLE_ENTRIES - 1));
  assign cnt_ext    = CMP_W'(cnt_q);
  // A limit above the capacity behaves as the capacity itself.
  assign full       = (cnt_ext >= CMP_W'(tlimit_q)) || (cnt_q == CNT_W'(TABLE_ENTRIES));

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    pipe_vld_d = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    free_d     = free_q;
    free_hit_d = free_hit_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    verdict_d  = verdict_q;
    out_vld_d  = out_vld_q && out_stall_i;
    rsp_d      = rsp_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;

    if ((state_q == ST_MATCH || state_q == ST_DECAY) &&
        (addr_q < (IDX_W + 1)'(TABLE_ENTRIES))) begin
      rd_en      = 1'b1;
      pipe_vld_d = 1'b1;
      cmp_idx_d  = addr_q[IDX_W-1:0];
      addr_d     = addr_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        addr_d     = '0;
        free_hit_d = 1'b0;
        if (req_q.requester_level >= bypass_q || tlimit_q == '0) begin
          verdict_d = VERDICT_BYPASS;
          state_d   = ST_DONE;
        end else begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (pipe_vld_q) begin
          if (!cur_valid && !free_hit_q) begin
            free_d     = cmp_idx_q;
            free_hit_d = 1'b1;
          end
          if (cur_valid && key_hit) begin
            verdict_d = VERDICT_KNOWN;
            state_d   = ST_DONE;
          end else if (last_entry) begin
            if (full) begin
              addr_d     = '0;
              pipe_vld_d = 1'b0;
              free_hit_d = 1'b0;
              state_d    = ST_DECAY;
            end else begin
              state_d = ST_DECIDE;
            end
          end
        end
      end
      ST_DECAY: begin
        if (pipe_vld_q) begin
          if (cur_valid && aged) begin
            valid_d[cmp_idx_q] = 1'b0;
            cnt_d              = cnt_q - 1'b1;
          end
          // The lowest slot that is free once this pass is over.
          if ((!cur_valid || aged) && !free_hit_q) begin
            free_d     = cmp_idx_q;
            free_hit_d = 1'b1;
          end
          if (last_entry) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (full) begin
          verdict_d = VERDICT_FULL;
        end else begin
          wr_en           = 1'b1;
          valid_d[free_q] = 1'b1;
          cnt_d           = cnt_q + 1'b1;
          verdict_d       = VERDICT_ADDED;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          rsp_d.allowed        = (verdict_q != VERDICT_FULL);
          rsp_d.verdict        = verdict_q;
          rsp_d.entries_in_use = cnt_ext[COUNT_W-1:0];
          out_vld_d            = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pipe_vld_q <= 1'b0;
      free_hit_q <= 1'b0;
      valid_q    <= '0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pipe_vld_q <= pipe_vld_d;
      free_hit_q <= free_hit_d;
      valid_q    <= valid_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      req_q <= req_i;
    end
    addr_q    <= addr_d;
    cmp_idx_q <= cmp_idx_d;
    free_q    <= free_d;
    verdict_q <= verdict_d;
    rsp_q     <= rsp_d;
  end

  assign out_valid_o = out_vld_q;
  assign rsp_o       = rsp_q;

endmodule
